// ----- hdl/jsd_pkg.sv -----
// ----------------------------------------------------------------------------
// jsd_pkg
// Shared types and constants of the job sequencing block.
// ----------------------------------------------------------------------------
package jsd_pkg;

    localparam int MAX_JOBS_DEF   = 16;
    localparam int SLOT_COUNT_DEF = 16;

    localparam int TAG_W    = 8;
    localparam int DL_W     = 8;
    localparam int PROFIT_W = 16;
    localparam int SLOT_W   = 5;
    localparam int SUM_W    = 20;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEL_INIT,
        ST_SEL_SCAN,
        ST_SEL_DONE,
        ST_RD_JOB,
        ST_WAIT_JOB,
        ST_SEARCH,
        ST_EMIT,
        ST_TOTAL
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic store;        // write input request into the job store
        logic clr_batch;    // clear counts, slots, used marks
        logic sel_init;     // start a best-profit scan
        logic sel_step;     // examine one stored job
        logic sel_take;     // mark the best as used, latch it
        logic rd_job;       // present selected index to the job store
        logic ld_job;       // latch job store read data
        logic srch_step;    // test one slot, walking down
        logic emit_job;     // load job result into the output register
        logic emit_total;   // load total item into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;         // job store full
        logic empty;        // no jobs stored
        logic sel_last;     // scan is on the last stored job
        logic srch_hit;     // current slot is free
        logic srch_end;     // slot search exhausted
        logic all_done;     // every stored job has been placed or skipped
        logic out_busy;     // output register holds an untaken request
    } t_sts;

endpackage

// ----- hdl/jsd_ram.sv -----
// ----------------------------------------------------------------------------
// jsd_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module jsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/jsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// jsd_ctrl
// Controller: load, select best job, search slot, emit results.
// ----------------------------------------------------------------------------
module jsd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_is_last_job,
    output logic           o_in_stall,
    output jsd_pkg::t_cmd  o_cmd,
    input  jsd_pkg::t_sts  i_sts
);

    jsd_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jsd_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            jsd_pkg::ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.store = !i_sts.full;
                    if (i_is_last_job) begin
                        n_state = jsd_pkg::ST_SEL_INIT;
                    end
                end
            end
            jsd_pkg::ST_SEL_INIT: begin
                o_cmd.sel_init = 1'b1;
                if (i_sts.all_done || i_sts.empty) begin
                    n_state = jsd_pkg::ST_TOTAL;
                end else begin
                    n_state = jsd_pkg::ST_SEL_SCAN;
                end
            end
            jsd_pkg::ST_SEL_SCAN: begin
                o_cmd.sel_step = 1'b1;
                if (i_sts.sel_last) begin
                    n_state = jsd_pkg::ST_SEL_DONE;
                end
            end
            jsd_pkg::ST_SEL_DONE: begin
                o_cmd.sel_take = 1'b1;
                n_state = jsd_pkg::ST_RD_JOB;
            end
            jsd_pkg::ST_RD_JOB: begin
                o_cmd.rd_job = 1'b1;
                n_state = jsd_pkg::ST_WAIT_JOB;
            end
            jsd_pkg::ST_WAIT_JOB: begin
                o_cmd.ld_job = 1'b1;
                n_state = jsd_pkg::ST_SEARCH;
            end
            jsd_pkg::ST_SEARCH: begin
                if (i_sts.srch_end) begin
                    n_state = jsd_pkg::ST_SEL_INIT;
                end else if (i_sts.srch_hit) begin
                    n_state = jsd_pkg::ST_EMIT;
                end else begin
                    o_cmd.srch_step = 1'b1;
                end
            end
            jsd_pkg::ST_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit_job = 1'b1;
                    n_state = jsd_pkg::ST_SEL_INIT;
                end
            end
            jsd_pkg::ST_TOTAL: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit_total = 1'b1;
                    o_cmd.clr_batch  = 1'b1;
                    n_state = jsd_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = jsd_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ----- hdl/jsd_dp.sv -----
// ----------------------------------------------------------------------------
// jsd_dp
// Datapath: job store, used marks, profit scan, slot table, output register.
// ----------------------------------------------------------------------------
module jsd_dp #(
    parameter int MAX_JOBS   = jsd_pkg::MAX_JOBS_DEF,
    parameter int SLOT_COUNT = jsd_pkg::SLOT_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jsd_pkg::t_cmd                 i_cmd,
    output jsd_pkg::t_sts                 o_sts,
    input  logic [jsd_pkg::TAG_W-1:0]     i_job_tag,
    input  logic [jsd_pkg::DL_W-1:0]      i_job_deadline,
    input  logic [jsd_pkg::PROFIT_W-1:0]  i_job_profit,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_has_job,
    output logic [jsd_pkg::TAG_W-1:0]     o_chosen_tag,
    output logic [jsd_pkg::SLOT_W-1:0]    o_chosen_slot,
    output logic [jsd_pkg::SUM_W-1:0]     o_profit_sum,
    output logic                          o_end_of_batch
);

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int SW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_JOBS);
    localparam logic [SW-1:0] SLOT_C = SW'(SLOT_COUNT);

    logic [CW-1:0] r_count;
    logic [MAX_JOBS-1:0] r_used;
    logic [SLOT_COUNT:1] r_slot_busy;
    logic [CW-1:0] r_done_cnt;

    // scan state
    logic [IW-1:0] r_scan_idx;
    logic [IW-1:0] r_best_idx;
    logic [jsd_pkg::PROFIT_W-1:0] r_best_profit;
    logic r_best_ok;
    logic [IW-1:0] r_job_idx;

    // current job
    logic [jsd_pkg::TAG_W-1:0] r_cur_tag;
    logic [jsd_pkg::PROFIT_W-1:0] r_cur_profit;
    logic [SW-1:0] r_slot;
    logic [jsd_pkg::SUM_W-1:0] r_sum;

    // output register
    logic r_out_valid;
    logic r_has_job;
    logic [jsd_pkg::TAG_W-1:0] r_o_tag;
    logic [jsd_pkg::SLOT_W-1:0] r_o_slot;
    logic [jsd_pkg::SUM_W-1:0] r_o_sum;
    logic r_o_end;

    logic [jsd_pkg::TAG_W-1:0] w_tag_rd;
    logic [jsd_pkg::DL_W-1:0] w_dl_rd;
    logic [jsd_pkg::PROFIT_W-1:0] w_pr_rd;
    logic [jsd_pkg::PROFIT_W-1:0] w_scan_pr;
    logic [IW-1:0] w_raddr;
    logic [IW-1:0] w_waddr;
    logic [SW-1:0] w_dl_sat;
    logic [jsd_pkg::SUM_W:0] w_sum_add;
    logic w_scan_take;

    assign w_waddr = r_count[IW-1:0];
    assign w_raddr = i_cmd.rd_job ? r_job_idx : r_scan_idx;

    // job store; one read port shared by the profit scan and the job fetch
    jsd_ram #(.WIDTH(jsd_pkg::TAG_W), .DEPTH(MAX_JOBS)) u_tag (
        .i_clk(i_clk), .i_we(i_cmd.store), .i_waddr(w_waddr),
        .i_wdata(i_job_tag), .i_raddr(w_raddr), .o_rdata(w_tag_rd));
    jsd_ram #(.WIDTH(jsd_pkg::DL_W), .DEPTH(MAX_JOBS)) u_dl (
        .i_clk(i_clk), .i_we(i_cmd.store), .i_waddr(w_waddr),
        .i_wdata(i_job_deadline), .i_raddr(w_raddr), .o_rdata(w_dl_rd));
    jsd_ram #(.WIDTH(jsd_pkg::PROFIT_W), .DEPTH(MAX_JOBS)) u_pr (
        .i_clk(i_clk), .i_we(i_cmd.store), .i_waddr(w_waddr),
        .i_wdata(i_job_profit), .i_raddr(w_raddr), .o_rdata(w_pr_rd));
    assign w_scan_pr = w_pr_rd;

    // scan pipeline: address r_scan_idx issued, data from the registered read port in the next cycle
    logic r_scan_vld;
    logic [IW-1:0] r_scan_pidx;
    logic [CW-1:0] w_scan_nxt;

    assign w_scan_nxt = CW'(r_scan_idx) + CW'(1);
    assign w_scan_take = r_scan_vld && !r_used[r_scan_pidx]
        && (!r_best_ok || w_scan_pr > r_best_profit);

    // saturated deadline
    always_comb begin
        if (w_dl_rd > jsd_pkg::DL_W'(SLOT_COUNT)) begin
            w_dl_sat = SLOT_C;
        end else begin
            w_dl_sat = SW'(w_dl_rd);
        end
    end

    assign w_sum_add = {1'b0, r_sum} + (jsd_pkg::SUM_W+1)'(r_cur_profit);

    // sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_used      <= '0;
            r_slot_busy <= '0;
            r_done_cnt  <= '0;
            r_sum       <= '0;
            r_scan_vld  <= 1'b0;
            r_best_ok   <= 1'b0;
        end else begin
            if (i_cmd.store && r_count != MAX_C) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.sel_init) begin
                r_scan_idx <= '0;
                r_scan_vld <= 1'b0;
                r_best_ok  <= 1'b0;
            end
            if (i_cmd.sel_step) begin
                r_scan_vld  <= 1'b1;
                r_scan_pidx <= r_scan_idx;
                if (w_scan_nxt < r_count) begin
                    r_scan_idx <= r_scan_idx + IW'(1);
                end
                if (w_scan_take) begin
                    r_best_ok     <= 1'b1;
                    r_best_profit <= w_scan_pr;
                    r_best_idx    <= r_scan_pidx;
                end
            end
            if (i_cmd.sel_take) begin
                // last scanned entry is evaluated here
                if (w_scan_take) begin
                    r_job_idx <= r_scan_pidx;
                    r_used[r_scan_pidx] <= 1'b1;
                end else begin
                    r_job_idx <= r_best_idx;
                    r_used[r_best_idx] <= 1'b1;
                end
                r_done_cnt <= r_done_cnt + CW'(1);
                r_scan_vld <= 1'b0;
            end
            if (i_cmd.ld_job) begin
                r_cur_tag    <= w_tag_rd;
                r_cur_profit <= w_pr_rd;
                r_slot       <= w_dl_sat;
            end
            if (i_cmd.srch_step) begin
                r_slot <= r_slot - SW'(1);
            end
            if (i_cmd.emit_job) begin
                r_slot_busy[r_slot] <= 1'b1;
                r_sum <= w_sum_add[jsd_pkg::SUM_W] ? jsd_pkg::SUM_MAX
                                                  : w_sum_add[jsd_pkg::SUM_W-1:0];
            end
            if (i_cmd.clr_batch) begin
                r_count     <= '0;
                r_used      <= '0;
                r_slot_busy <= '0;
                r_done_cnt  <= '0;
                r_sum       <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_job || i_cmd.emit_total) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_job) begin
            r_has_job <= 1'b1;
            r_o_tag   <= r_cur_tag;
            r_o_slot  <= jsd_pkg::SLOT_W'(r_slot);
            r_o_sum   <= w_sum_add[jsd_pkg::SUM_W] ? jsd_pkg::SUM_MAX
                                                   : w_sum_add[jsd_pkg::SUM_W-1:0];
            r_o_end   <= 1'b0;
        end else if (i_cmd.emit_total) begin
            r_has_job <= 1'b0;
            r_o_tag   <= '0;
            r_o_slot  <= '0;
            r_o_sum   <= r_sum;
            r_o_end   <= 1'b1;
        end
    end

    // status
    always_comb begin
        o_sts           = '0;
        o_sts.full      = (r_count == MAX_C);
        o_sts.empty     = (r_count == '0);
        o_sts.sel_last  = r_scan_vld && (CW'(r_scan_pidx) + CW'(1) >= r_count);
        o_sts.srch_end  = (r_slot == '0);
        o_sts.srch_hit  = (r_slot != '0) && !r_slot_busy[r_slot];
        o_sts.all_done  = (r_done_cnt == r_count);
        o_sts.out_busy  = r_out_valid && i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_has_job      = r_has_job;
    assign o_chosen_tag   = r_o_tag;
    assign o_chosen_slot  = r_o_slot;
    assign o_profit_sum   = r_o_sum;
    assign o_end_of_batch = r_o_end;

endmodule

// ----- hdl/job_sequencing_deadlines.sv -----
// ----------------------------------------------------------------------------
// job_sequencing_deadlines
// Greedy job sequencing with deadlines over a stored batch.
// ----------------------------------------------------------------------------
// Jobs are loaded one request per cycle; the request with i_is_last_job set
// closes the batch. For each of the n stored jobs the controller scans the
// job store for the highest unused profit through the store's registered
// read port, then walks the slot table down from the deadline (one slot per
// cycle) to the first free slot; a job that finds no slot is skipped. A
// stalled output holds the controller until the result is taken. Results
// leave through one output register; the last result of a batch, flagged
// end of batch, carries the total. Input is stalled while a batch is
// scheduled.
module job_sequencing_deadlines #(
    parameter int MAX_JOBS   = jsd_pkg::MAX_JOBS_DEF,
    parameter int SLOT_COUNT = jsd_pkg::SLOT_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [jsd_pkg::TAG_W-1:0]     i_job_tag,
    input  logic [jsd_pkg::DL_W-1:0]      i_job_deadline,
    input  logic [jsd_pkg::PROFIT_W-1:0]  i_job_profit,
    input  logic                          i_is_last_job,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_has_job,
    output logic [jsd_pkg::TAG_W-1:0]     o_chosen_tag,
    output logic [jsd_pkg::SLOT_W-1:0]    o_chosen_slot,
    output logic [jsd_pkg::SUM_W-1:0]     o_profit_sum,
    output logic                          o_end_of_batch
);

    jsd_pkg::t_cmd w_cmd;
    jsd_pkg::t_sts w_sts;

    jsd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_is_last_job(i_is_last_job),
        .o_in_stall(o_in_stall), .o_cmd(w_cmd), .i_sts(w_sts));

    jsd_dp #(.MAX_JOBS(MAX_JOBS), .SLOT_COUNT(SLOT_COUNT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_job_tag(i_job_tag), .i_job_deadline(i_job_deadline),
        .i_job_profit(i_job_profit),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_has_job(o_has_job), .o_chosen_tag(o_chosen_tag),
        .o_chosen_slot(o_chosen_slot), .o_profit_sum(o_profit_sum),
        .o_end_of_batch(o_end_of_batch));

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives batches of jobs into the greedy job sequencer and checks every
// scheduled job and batch total against an in-bench model of the schedule.
// ----------------------------------------------------------------------------

// Schedule predictor and store of expected results
class schedule_board;
    typedef struct packed {
        logic        has_job;
        logic [7:0]  tag;
        logic [4:0]  slot;
        logic [19:0] sum;
        logic        eob;
    } t_res;

    localparam int JOBS  = 16;
    localparam int SLOTS = 16;

    logic [7:0]  st_tag [JOBS];
    logic [7:0]  st_dl [JOBS];
    logic [15:0] st_profit [JOBS];
    int          n_stored;
    t_res        pending[$];
    int          errors;
    int          n_checked;
    int          n_batches;

    function new();
        n_stored = 0;
        errors = 0;
        n_checked = 0;
        n_batches = 0;
    endfunction

    // Note one accepted request; a closing request schedules the batch
    function void note_job(logic [7:0] tag, logic [7:0] dl, logic [15:0] pr,
                           logic last);
        int   order [JOBS];
        bit   taken [SLOTS+1];
        int   i, j, cur, d;
        logic [20:0] sum;
        t_res r;
        if (n_stored < JOBS) begin
            st_tag[n_stored] = tag;
            st_dl[n_stored] = dl;
            st_profit[n_stored] = pr;
            n_stored++;
        end
        if (!last) return;
        // stable sort by falling profit
        for (i = 0; i < n_stored; i++) begin
            cur = i;
            j = i;
            while (j > 0 && st_profit[order[j-1]] < st_profit[cur]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        for (i = 0; i <= SLOTS; i++) taken[i] = 0;
        sum = 0;
        for (i = 0; i < n_stored; i++) begin
            d = st_dl[order[i]];
            if (d > SLOTS) d = SLOTS;
            for (j = d; j > 0; j--) begin
                if (!taken[j]) begin
                    taken[j] = 1;
                    sum = sum + st_profit[order[i]];
                    if (sum > 21'hFFFFF) sum = 21'hFFFFF;
                    r = '{1'b1, st_tag[order[i]], 5'(j), sum[19:0], 1'b0};
                    pending.push_back(r);
                    break;
                end
            end
        end
        r = '{1'b0, 8'd0, 5'd0, sum[19:0], 1'b1};
        pending.push_back(r);
        n_stored = 0;
        n_batches++;
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(t_res got);
        t_res exp_r;
        n_checked++;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("MISMATCH: unexpected result %h", got);
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
                $display("MISMATCH: has=%0d/%0d tag=%0d/%0d slot=%0d/%0d sum=%0d/%0d eob=%0d/%0d",
                         got.has_job, exp_r.has_job, got.tag, exp_r.tag,
                         got.slot, exp_r.slot, got.sum, exp_r.sum,
                         got.eob, exp_r.eob);
        end
    endfunction
endclass

module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [7:0]  i_job_tag = 0;
    logic [7:0]  i_job_deadline = 0;
    logic [15:0] i_job_profit = 0;
    logic        i_is_last_job = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic        o_has_job;
    logic [7:0]  o_chosen_tag;
    logic [4:0]  o_chosen_slot;
    logic [19:0] o_profit_sum;
    logic        o_end_of_batch;

    schedule_board board = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int n_sent = 0;

    job_sequencing_deadlines dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // Receiver: random stall, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result('{o_has_job, o_chosen_tag, o_chosen_slot,
                                 o_profit_sum, o_end_of_batch});
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Present one request and hold it until accepted; valid stays up after
    // acceptance so the next request can follow without a gap
    task automatic send_job(logic [7:0] tag, logic [7:0] dl, logic [15:0] pr,
                            logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_job_tag <= tag;
        i_job_deadline <= dl;
        i_job_profit <= pr;
        i_is_last_job <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_job(tag, dl, pr, last);
        n_sent++;
    endtask

    // A batch of n jobs with random content, profits drawn from a narrow or wide range
    task automatic send_batch(int n);
        int i;
        bit narrow;
        narrow = 1'($urandom_range(1));
        for (i = 0; i < n; i++)
            send_job(8'($urandom),
                     8'(($urandom_range(9) == 0) ? $urandom : $urandom_range(20)),
                     16'(narrow ? $urandom_range(4) : $urandom), i == n - 1);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int ph;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: single job, zero deadline, saturating deadline, extremes
        send_job(8'hFF, 8'd0, 16'hFFFF, 1);
        send_job(8'h00, 8'd255, 16'hFFFF, 1);
        send_job(8'hA5, 8'd1, 16'd0, 0);
        send_job(8'h5A, 8'd1, 16'd0, 0);
        send_job(8'h33, 8'd16, 16'hFFFF, 0);
        send_job(8'hCC, 8'd17, 16'hFFFF, 1);
        // overflow: 18 jobs, the last two dropped, but the last one starts the computation
        for (int i = 0; i < 18; i++)
            send_job(8'(i), 8'd255, 16'hFFFF - 16'(i & 1), i == 17);
        drain();
        // random phases with different idle/stall mixes
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 70 : 30) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 70 : 30) : 0;
            while (n_sent < 25 + (ph + 1) * 120)
                send_batch(($urandom_range(7) == 0) ? $urandom_range(15, 18)
                                                     : $urandom_range(1, 8));
            drain();
        end
        repeat (50) @(posedge i_clk);
        $display("Run covered %0d job requests in %0d batches, %0d results checked.",
                 n_sent, board.n_batches, board.n_checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
